// ===== src/ebpfpf_pkg.sv =====
package ebpfpf_pkg;

    // Default program capacity in instruction words
    localparam int unsigned DEF_MAX_INSTRUCTIONS = 4096;

    // Helper ids 0 .. HELPER_ID_COUNT-1 can be registered (at most 64)
    localparam int unsigned HELPER_ID_COUNT = 64;

    // Configuration port geometry and register indexes
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 64;

    localparam logic [CFG_ADDR_W-1:0] CFG_PROGRAM_LENGTH = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ALLOW_NO_RETURN = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HELPER_MASK = 2'd2;

    // Opcode decoding
    localparam logic [7:0] CLASS_MASK = 8'h07;
    localparam logic [7:0] CLASS_BRANCH = 8'h05;
    localparam logic [7:0] OP_WIDE_LOAD = 8'h18;
    localparam logic [7:0] OP_CALL = 8'h85;
    localparam logic [7:0] OP_EXIT = 8'h95;
    localparam logic [3:0] REG_LIMIT = 4'd11;

    localparam int unsigned S_TDATA_W = 64;
    localparam int unsigned M_TDATA_W = 8;
    localparam int unsigned STATUS_W = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK = 3'd0,
        ST_LEN = 3'd1,
        ST_REG = 3'd2,
        ST_JUMP = 3'd3,
        ST_CALL = 3'd4,
        ST_NORET = 3'd5
    } status_t;

    // One instruction word, opcode in the lowest bits
    typedef struct packed {
        logic [31:0] immediate_value;
        logic [15:0] jump_offset;
        logic [3:0]  source_reg;
        logic [3:0]  dest_reg;
        logic [7:0]  opcode;
    } insn_t;

    // Per-program control state carried between words
    typedef struct packed {
        logic    skip_next_word;
        status_t first_error;
    } ctl_t;

    // Configuration seen by the word checker
    typedef struct packed {
        logic [15:0] program_length_bytes;
        logic        allow_no_return;
        logic [63:0] helper_allow_mask;
    } cfg_t;

endpackage

// ===== src/ebpfpf_word_check.sv =====
module ebpfpf_word_check
    import ebpfpf_pkg::*;
#(
    parameter int unsigned MAX_INSTRUCTIONS = DEF_MAX_INSTRUCTIONS,
    localparam int unsigned IDX_W = $clog2(MAX_INSTRUCTIONS + 1)
) (
    input  insn_t            insn,
    input  logic             last_word,
    input  cfg_t             cfg,
    input  ctl_t             ctl,
    input  logic [IDX_W-1:0] word_index,
    output ctl_t             ctl_next,
    output logic [IDX_W-1:0] word_index_next,
    output status_t          status
);

    localparam int unsigned MAX_BYTES = MAX_INSTRUCTIONS * 8;
    localparam int unsigned TGT_W = ((IDX_W > 16) ? IDX_W : 16) + 2;
    localparam int unsigned CNT_W = 13;

    logic [CNT_W-1:0]        count;
    logic                    length_bad;
    logic signed [TGT_W-1:0] target;
    logic [TGT_W-1:0]        count_ext;
    logic [TGT_W-1:0]        index_ext;
    logic                    jump_bad;
    logic                    call_bad;
    logic                    reg_bad;

    assign count = cfg.program_length_bytes[15:3];
    assign count_ext = {{(TGT_W - CNT_W){1'b0}}, count};
    assign index_ext = {{(TGT_W - IDX_W){1'b0}}, word_index};

    assign length_bad = (cfg.program_length_bytes == 16'd0)
                     || (cfg.program_length_bytes[2:0] != 3'd0)
                     || ({16'd0, cfg.program_length_bytes} > 32'(MAX_BYTES));

    assign target = $signed(index_ext)
                  + $signed({{(TGT_W - 16){insn.jump_offset[15]}}, insn.jump_offset});
    assign jump_bad = target[TGT_W-1] || (unsigned'(target) >= count_ext);

    assign call_bad = insn.immediate_value[31]
                   || (insn.immediate_value[30:0] >= 31'(HELPER_ID_COUNT))
                   || !cfg.helper_allow_mask[insn.immediate_value[5:0]];

    assign reg_bad = (insn.dest_reg >= REG_LIMIT) || (insn.source_reg >= REG_LIMIT);

    always_comb begin
        status_t fe;
        logic    skip;

        fe = ctl.first_error;
        skip = ctl.skip_next_word;

        if (length_bad && fe == ST_OK) begin
            fe = ST_LEN;
        end

        if (ctl.skip_next_word) begin
            skip = 1'b0;
        end else if (reg_bad) begin
            if (fe == ST_OK) fe = ST_REG;
        end else if (insn.opcode == OP_WIDE_LOAD) begin
            skip = 1'b1;
        end else begin
            if ((insn.opcode & CLASS_MASK) == CLASS_BRANCH && jump_bad && fe == ST_OK) begin
                fe = ST_JUMP;
            end
            if (insn.opcode == OP_CALL && call_bad && fe == ST_OK) begin
                fe = ST_CALL;
            end
        end

        if (last_word) begin
            if ((count == '0 || index_ext != count_ext - TGT_W'(1)) && fe == ST_OK) begin
                fe = ST_LEN;
            end
            if (insn.opcode != OP_EXIT && !cfg.allow_no_return && fe == ST_OK) begin
                fe = ST_NORET;
            end
            status = fe;
            ctl_next.skip_next_word = 1'b0;
            ctl_next.first_error = ST_OK;
            word_index_next = '0;
        end else begin
            status = fe;
            ctl_next.skip_next_word = skip;
            ctl_next.first_error = fe;
            // saturate at the program capacity
            if (word_index < IDX_W'(MAX_INSTRUCTIONS)) begin
                word_index_next = word_index + IDX_W'(1);
            end else begin
                word_index_next = word_index;
            end
        end
    end

endmodule

// ===== src/ebpf_program_preflight_checker.sv =====
// eBPF program preflight checker: one 8-byte instruction word in, one status word out.
// A word passes the input register, then the result register, before m_tvalid rises.
// Throughput: one word per cycle unless m_tready stalls; the checks for a word are
// compares and one add between the input register and the result register.
// Reset (aresetn low, synchronous): both stages empty, configuration cleared to zero,
// word index, skip flag and latched error cleared.
module ebpf_program_preflight_checker
    import ebpfpf_pkg::*;
#(
    parameter int unsigned MAX_INSTRUCTIONS = DEF_MAX_INSTRUCTIONS
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    // instruction words
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // opcode[7:0], dest_reg[11:8], source_reg[15:12], jump_offset[31:16],
    // immediate_value[63:32]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,   // last_word

    // status words
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // status[2:0], zero fill [7:3]
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tlast    // verdict_valid
);

    localparam int unsigned IDX_W = $clog2(MAX_INSTRUCTIONS + 1);

    // configuration registers
    cfg_t cfg_reg;

    // input stage
    logic  in_valid_reg;
    insn_t insn_reg;
    logic  in_last_reg;

    // result stage
    logic    out_valid_reg;
    status_t status_reg;
    logic    verdict_reg;

    // program state
    ctl_t             ctl_reg;
    ctl_t             ctl_next;
    logic [IDX_W-1:0] word_index_reg;
    logic [IDX_W-1:0] word_index_next;
    status_t          status_next;

    logic out_ready;
    logic advance;

    // The result register frees when empty or taken; the input register frees
    // when empty or when its word moves on into the result register.
    assign out_ready = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_ready;
    assign advance = in_valid_reg && out_ready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {{(M_TDATA_W - STATUS_W){1'b0}}, status_reg};
    assign m_tlast = verdict_reg;

    // Configuration writes; an index past the list is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_PROGRAM_LENGTH: cfg_reg.program_length_bytes <= cfg_wdata[15:0];
                CFG_ALLOW_NO_RETURN: cfg_reg.allow_no_return <= cfg_wdata[0];
                CFG_HELPER_MASK: cfg_reg.helper_allow_mask <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register: capture a word whenever the slave side handshakes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            insn_reg <= insn_t'(s_tdata);
            in_last_reg <= s_tlast;
        end
    end

    ebpfpf_word_check #(
        .MAX_INSTRUCTIONS(MAX_INSTRUCTIONS)
    ) u_check (
        .insn           (insn_reg),
        .last_word      (in_last_reg),
        .cfg            (cfg_reg),
        .ctl            (ctl_reg),
        .word_index     (word_index_reg),
        .ctl_next       (ctl_next),
        .word_index_next(word_index_next),
        .status         (status_next)
    );

    // Program state advances once per word that moves into the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '{skip_next_word: 1'b0, first_error: ST_OK};
            word_index_reg <= '0;
        end else if (advance) begin
            ctl_reg <= ctl_next;
            word_index_reg <= word_index_next;
        end
    end

    // Result register: hold while stalled, load on advance, drop when taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            status_reg <= status_next;
            verdict_reg <= in_last_reg;
        end
    end

endmodule

// ===== src/ebpfpf_checker.sv =====
module ebpfpf_checker
    import ebpfpf_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    logic                in_program_reg;
    logic [STATUS_W-1:0] seen_status_reg;

    // Track the status of the last word delivered inside the current program.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_program_reg <= 1'b0;
            seen_status_reg <= '0;
        end else if (m_tvalid && m_tready) begin
            in_program_reg <= !m_tlast;
            seen_status_reg <= m_tdata[STATUS_W-1:0];
        end
    end

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("status word dropped while stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[STATUS_W-1:0] <= ST_NORET)
                     && (m_tdata[M_TDATA_W-1:STATUS_W] == '0))
        else $error("status word out of range");

    a_error_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && in_program_reg && (seen_status_reg != ST_OK)
        |-> m_tdata[STATUS_W-1:0] == seen_status_reg)
        else $error("latched error changed within a program");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

endmodule

bind ebpf_program_preflight_checker ebpfpf_checker u_ebpfpf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);

// ===== tb/ebpf_program_preflight_checker_tb.sv =====
`timescale 1ns / 1ps

module ebpf_program_preflight_checker_tb;
    import ebpfpf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AFTER     = 150;   // results seen before the long receiver hold-off

    // One instruction word as offered on the input channel
    typedef struct packed {
        logic  last;
        insn_t insn;
    } word_t;

    // What the checker must report for one word
    typedef struct {
        status_t status;
        logic    verdict;
    } result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // opcode, dest_reg, source_reg, jump_offset, immediate_value
    logic                  s_tlast;   // last_word
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // status, zero fill
    logic                  m_tlast;   // verdict_valid

    ebpf_program_preflight_checker i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Words waiting to be offered, and verdicts waiting to come out
    word_t   insn_q[$];
    result_t status_q[$];
    word_t   cur_word;

    // Shadow of the configuration registers
    logic [15:0] prog_len;
    logic        no_ret_ok;
    logic [63:0] helper_mask;

    // Shadow of the per-program checking state
    int      word_idx;
    logic    skip_word;
    status_t latched_err;

    // Idling controls, set by the sequencer between phases
    int   gap_pct;
    int   stall_pct;
    logic quiet;

    int gap_cnt;
    int stall_cnt;
    int hold_cnt;
    int results;
    int mismatches;
    int idle_cycles;
    int queued_words;

    // ------------------------------------------------------------------
    // Checking model
    // ------------------------------------------------------------------

    // Keep the earliest error of the program; drop later ones
    function automatic void note_error(status_t code);
        if (latched_err == ST_OK)
            latched_err = code;
    endfunction

    // Run one accepted word through the program checks and advance the state
    function automatic result_t check_word(insn_t w, logic last);
        result_t res;
        int      count;
        int      target;
        int      helper;
        count = int'(prog_len) / 8;
        if (prog_len == 16'd0 || prog_len[2:0] != 3'd0 ||
            int'(prog_len) > int'(DEF_MAX_INSTRUCTIONS) * 8)
            note_error(ST_LEN);

        if (skip_word) begin
            // second half of a wide load: counted, never checked
            skip_word = 1'b0;
        end else if (w.dest_reg >= REG_LIMIT || w.source_reg >= REG_LIMIT) begin
            note_error(ST_REG);
        end else if (w.opcode == OP_WIDE_LOAD) begin
            skip_word = 1'b1;
        end else begin
            // exit and call belong to the branch class too
            if ((w.opcode & CLASS_MASK) == CLASS_BRANCH) begin
                target = word_idx + int'($signed(w.jump_offset));
                if (target < 0 || target >= count)
                    note_error(ST_JUMP);
            end
            helper = int'($signed(w.immediate_value));
            if (w.opcode == OP_CALL) begin
                if (helper < 0 || helper >= int'(HELPER_ID_COUNT))
                    note_error(ST_CALL);
                else if (!helper_mask[helper])
                    note_error(ST_CALL);
            end
        end

        if (last) begin
            // stream length mismatch ranks below the word's own checks
            if (count == 0 || word_idx != count - 1)
                note_error(ST_LEN);
            // a skipped final word still has its opcode looked at here
            if (w.opcode != OP_EXIT && !no_ret_ok)
                note_error(ST_NORET);
            res.status  = latched_err;
            res.verdict = 1'b1;
            word_idx    = 0;
            skip_word   = 1'b0;
            latched_err = ST_OK;
        end else begin
            res.status  = latched_err;
            res.verdict = 1'b0;
            // saturate the word counter at the program capacity
            if (word_idx < int'(DEF_MAX_INSTRUCTIONS))
                word_idx++;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Program generation
    // ------------------------------------------------------------------

    // Offset that lands the branch inside the program
    function automatic logic [15:0] branch_offset(int idx, int count);
        int tgt;
        if (count <= 0)
            return 16'($urandom);
        tgt = $urandom_range(0, count - 1);
        return 16'(tgt - idx);
    endfunction

    // Helper id with its bit set, if any is set
    function automatic logic [31:0] pick_helper();
        int id;
        if (helper_mask == 64'd0)
            return 32'($urandom_range(0, 63));
        do
            id = $urandom_range(0, 63);
        while (!helper_mask[id]);
        return 32'(id);
    endfunction

    // Random word that passes every per-word check
    function automatic insn_t legal_insn(int idx, int count);
        insn_t w;
        int    pick;
        w.dest_reg        = 4'($urandom_range(0, 10));
        w.source_reg      = 4'($urandom_range(0, 10));
        w.jump_offset     = 16'($urandom);
        w.immediate_value = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            // plain word: keep it out of the branch class and off the wide load
            w.opcode = 8'($urandom);
            if ((w.opcode & CLASS_MASK) == CLASS_BRANCH)
                w.opcode[0] = 1'b0;
            if (w.opcode == OP_WIDE_LOAD)
                w.opcode = 8'h07;
        end else begin
            if (pick < 70)
                w.opcode = {5'($urandom), 3'b101};
            else
                w.opcode = OP_CALL;
            w.jump_offset = branch_offset(idx, count);
            if (w.opcode == OP_CALL)
                w.immediate_value = pick_helper();
        end
        return w;
    endfunction

    // Plant one kind of per-word fault into a word
    function automatic insn_t break_insn(insn_t w, int idx, int count, int kind);
        case (kind)
            1: w.dest_reg = 4'($urandom_range(11, 15));
            2: w.source_reg = 4'($urandom_range(11, 15));
            3: begin
                w.opcode = {5'($urandom), 3'b101};
                if ($urandom_range(0, 1))
                    w.jump_offset = 16'(count - idx + int'($urandom_range(0, 40)));
                else
                    w.jump_offset = 16'(-idx - 1 - int'($urandom_range(0, 40)));
            end
            default: begin
                w.opcode      = OP_CALL;
                w.jump_offset = branch_offset(idx, count);
                if ($urandom_range(0, 1))
                    w.immediate_value = $urandom;
                else
                    w.immediate_value = 32'($urandom_range(0, 63));
            end
        endcase
        return w;
    endfunction

    task automatic push_insn(input logic [7:0] op, input logic [3:0] dst,
                             input logic [3:0] src, input logic [15:0] off,
                             input logic [31:0] imm, input logic last);
        word_t w;
        w.insn.opcode          = op;
        w.insn.dest_reg        = dst;
        w.insn.source_reg      = src;
        w.insn.jump_offset     = off;
        w.insn.immediate_value = imm;
        w.last                 = last;
        insn_q.push_back(w);
        queued_words++;
    endtask

    // Queue one program of n words; clean programs carry no planted fault
    task automatic queue_program(input int count, input int n, input logic clean);
        word_t w;
        int    fault;
        int    fault_at;
        int    i;
        logic  skip;
        fault = (clean || $urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 6);
        if (fault == 6) begin
            // stream ends early or late against the programmed length
            if ($urandom_range(0, 1))
                n = n + $urandom_range(1, 3);
            else if (n > 1)
                n = $urandom_range(1, n - 1);
        end
        fault_at = $urandom_range(0, n - 1);
        skip = 1'b0;
        for (i = 0; i < n; i++) begin
            if (skip) begin
                // word behind a wide load: anything goes
                w.insn = {$urandom, $urandom};
                if (i == n - 1 && $urandom_range(0, 3) != 0)
                    w.insn.opcode = OP_EXIT;
                skip = 1'b0;
            end else if (i == n - 1) begin
                w.insn             = legal_insn(i, count);
                w.insn.opcode      = OP_EXIT;
                w.insn.jump_offset = branch_offset(i, count);
            end else if ($urandom_range(0, 9) == 0) begin
                w.insn        = legal_insn(i, count);
                w.insn.opcode = OP_WIDE_LOAD;
                skip          = 1'b1;
            end else begin
                w.insn = legal_insn(i, count);
            end
            if (fault >= 1 && fault <= 4 && i == fault_at)
                w.insn = break_insn(w.insn, i, count, fault);
            if (fault == 5 && i == n - 1) begin
                w.insn.opcode = 8'($urandom);
                if (w.insn.opcode == OP_EXIT)
                    w.insn.opcode = 8'h00;
            end
            w.last = (i == n - 1);
            insn_q.push_back(w);
            queued_words++;
        end
    endtask

    // Queue fully random words, an occasional one marked last
    task automatic queue_noise(input int k);
        word_t w;
        int    i;
        for (i = 0; i < k; i++) begin
            w.insn = {$urandom, $urandom};
            w.last = ($urandom_range(0, 5) == 0);
            insn_q.push_back(w);
            queued_words++;
        end
    endtask

    // ------------------------------------------------------------------
    // Configuration and phase control
    // ------------------------------------------------------------------

    // Write one register and mirror it in the shadow copy
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        case (addr)
            CFG_PROGRAM_LENGTH:  prog_len    = data[15:0];
            CFG_ALLOW_NO_RETURN: no_ret_ok   = data[0];
            CFG_HELPER_MASK:     helper_mask = data;
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Hold until every queued word is in and every verdict is out, then let
    // the two pipeline stages drain
    task automatic wait_idle();
        do
            @(negedge aclk);
        while (insn_q.size() != 0 || s_tvalid || status_q.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Input driver: offer queued words, with random gaps between them
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
            gap_cnt  = 0;
        end else begin
            // predict on the word that is taken at this edge
            if (s_tvalid && s_tready)
                status_q.push_back(check_word(cur_word.insn, cur_word.last));
            // advance only once the current word is gone
            if (!s_tvalid || s_tready) begin
                if (gap_cnt > 0) begin
                    gap_cnt--;
                    s_tvalid <= 1'b0;
                end else if (insn_q.size() != 0 && !quiet &&
                             $urandom_range(0, 99) < gap_pct) begin
                    gap_cnt  = $urandom_range(1, 17) - 1;
                    s_tvalid <= 1'b0;
                end else if (insn_q.size() != 0) begin
                    cur_word = insn_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur_word.insn;
                    s_tlast  <= cur_word.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output monitor: check each status word, stall the result channel
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            stall_cnt = 0;
            hold_cnt  = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results++;
                if (status_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected status word: status %0d last %0b",
                                 m_tdata[STATUS_W-1:0], m_tlast);
                end else begin
                    want = status_q.pop_front();
                    if (m_tdata[STATUS_W-1:0] !== want.status || m_tlast !== want.verdict) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("word %0d: status exp %0d got %0d, last exp %0b got %0b",
                                     results, want.status, m_tdata[STATUS_W-1:0],
                                     want.verdict, m_tlast);
                    end
                end
                // one long hold-off so the input side backs up and stalls
                if (results == HOLD_AFTER)
                    hold_cnt = HOLD_CYCLES;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else if (stall_cnt > 0) begin
                stall_cnt--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
                stall_cnt = $urandom_range(1, 17) - 1;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when nothing moves for too long
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("ebpf_program_preflight_checker: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: reset, directed programs, long programs, random phases
    // ------------------------------------------------------------------
    initial begin
        int          phase;
        int          len;
        int          count;
        int          n;
        int          phase_end;
        logic [63:0] mask;

        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_addr     = '0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        m_tready     = 1'b0;
        prog_len     = '0;
        no_ret_ok    = 1'b0;
        helper_mask  = '0;
        word_idx     = 0;
        skip_word    = 1'b0;
        latched_err  = ST_OK;
        gap_pct      = 20;
        stall_pct    = 20;
        quiet        = 1'b0;
        results      = 0;
        mismatches   = 0;
        idle_cycles  = 0;
        queued_words = 0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset configuration: length zero must flag without reading anything
        push_insn(OP_EXIT, 4'd0, 4'd0, 16'd0, 32'd0, 1'b1);
        wait_idle();

        // Four-word programs, helpers 0 and 63 registered
        write_reg(CFG_PROGRAM_LENGTH, 64'd32);
        write_reg(CFG_ALLOW_NO_RETURN, 64'd0);
        write_reg(CFG_HELPER_MASK, 64'h8000_0000_0000_0001);
        @(negedge aclk);

        // Wide load hides a word full of faults; top helper id; clean exit
        push_insn(OP_WIDE_LOAD, 4'd10, 4'd10, 16'd0, 32'd0, 1'b0);
        push_insn(OP_CALL, 4'd15, 4'd15, 16'h8000, 32'hFFFF_FFFF, 1'b0);
        push_insn(OP_CALL, 4'd0, 4'd0, 16'd0, 32'd63, 1'b0);
        push_insn(OP_EXIT, 4'd0, 4'd0, 16'd0, 32'd0, 1'b1);
        // Bad destination first, then a bad source and a wild jump that lose
        push_insn(8'h07, 4'd11, 4'd0, 16'd0, 32'd0, 1'b0);
        push_insn(8'hBF, 4'd0, 4'd15, 16'd0, 32'd0, 1'b0);
        push_insn(8'h05, 4'd0, 4'd0, 16'h8000, 32'h7FFF_FFFF, 1'b0);
        push_insn(OP_EXIT, 4'd0, 4'd0, 16'd0, 32'd0, 1'b1);
        // Jump to the last word is fine; jump before the first is not
        push_insn(8'h05, 4'd0, 4'd0, 16'd3, 32'd0, 1'b0);
        push_insn(8'h15, 4'd1, 4'd2, 16'hFFFE, 32'd0, 1'b0);
        push_insn(OP_CALL, 4'd0, 4'd0, 16'h7FFF, 32'd5, 1'b0);
        push_insn(OP_EXIT, 4'd0, 4'd0, 16'd0, 32'd0, 1'b1);
        // Negative helper id, then a stream that stops short
        push_insn(OP_CALL, 4'd0, 4'd0, 16'd0, 32'h8000_0000, 1'b0);
        push_insn(OP_EXIT, 4'd0, 4'd0, 16'd0, 32'd0, 1'b1);
        // Missing exit at the end
        push_insn(8'h07, 4'd0, 4'd0, 16'd0, 32'd0, 1'b0);
        push_insn(8'h07, 4'd0, 4'd0, 16'd0, 32'd0, 1'b0);
        push_insn(8'h07, 4'd0, 4'd0, 16'd0, 32'd0, 1'b0);
        push_insn(8'h07, 4'd0, 4'd0, 16'd0, 32'd0, 1'b1);
        // Single word marked last at the wrong place
        push_insn(OP_EXIT, 4'd0, 4'd0, 16'd0, 32'd0, 1'b1);
        // Wide load covers the final word: skipped, but its exit still counts
        push_insn(8'h07, 4'd0, 4'd0, 16'd0, 32'd0, 1'b0);
        push_insn(8'h07, 4'd0, 4'd0, 16'd0, 32'd0, 1'b0);
        push_insn(OP_WIDE_LOAD, 4'd0, 4'd0, 16'd0, 32'd0, 1'b0);
        push_insn(OP_EXIT, 4'd15, 4'd15, 16'h8000, 32'd0, 1'b1);
        wait_idle();

        // Full-size length with branches across the whole range, and a
        // stream that stops far short of it
        write_reg(CFG_PROGRAM_LENGTH, 64'(DEF_MAX_INSTRUCTIONS * 8));
        write_reg(CFG_HELPER_MASK, '1);
        gap_pct   = 5;
        stall_pct = 5;
        @(negedge aclk);
        queue_program(DEF_MAX_INSTRUCTIONS, 40, 1'b1);

        // Random phases: new settings each time, mostly well-formed programs
        for (phase = 0; phase < 10; phase++) begin
            wait_idle();
            case ($urandom_range(0, 9))
                0: len = $urandom_range(0, 1) ? 0
                                              : 8 * $urandom_range(1, 30) + $urandom_range(1, 7);
                1: case ($urandom_range(0, 2))
                    0:       len = 16'hFFFF;
                    1:       len = 16'hFFF8;
                    default: len = DEF_MAX_INSTRUCTIONS * 8 + 8;
                endcase
                default: len = 8 * $urandom_range(1, 24);
            endcase
            case ($urandom_range(0, 3))
                0:       mask = '0;
                1:       mask = '1;
                default: mask = {$urandom, $urandom};
            endcase
            write_reg(CFG_PROGRAM_LENGTH, 64'(len));
            write_reg(CFG_ALLOW_NO_RETURN, 64'($urandom_range(0, 1)));
            write_reg(CFG_HELPER_MASK, mask);
            // vary which side idles; the last phase runs flat out
            gap_pct   = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 10 : 35);
            stall_pct = (phase % 3 == 2) ? 0 : ((phase % 3 == 0) ? 10 : 35);
            quiet     = (phase == 9);
            @(negedge aclk);
            phase_end = queued_words + 70;
            while (queued_words < phase_end) begin
                if ($urandom_range(0, 9) == 0) begin
                    queue_noise($urandom_range(1, 6));
                end else begin
                    count = len / 8;
                    n = (count >= 1 && count <= 32) ? count : $urandom_range(1, 24);
                    queue_program(count, n, 1'b0);
                end
            end
        end

        wait_idle();
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("ebpf_program_preflight_checker: match");
        end else begin
            $display("ebpf_program_preflight_checker: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/ebpfpf_pkg.sv
src/ebpfpf_word_check.sv
src/ebpf_program_preflight_checker.sv
src/ebpfpf_checker.sv
tb/ebpf_program_preflight_checker_tb.sv
